/* hw/rtl/ppfd_pkg.sv */
package ppfd_pkg;

    // Default sizes, handed to the top level parameters
    localparam int NUM_PIECES_DEF      = 38;
    localparam int PIECE_CODE_BITS_DEF = 11;

    // Fixed field widths of the stream payload
    localparam int SLOT_W       = 6;
    localparam int CODE_FIELD_W = 11;
    localparam int COUNT_W      = 2;
    localparam int IDX_W        = 21;
    localparam int IN_DATA_W    = 64;
    localparam int IN_USER_W    = 2;
    localparam int OUT_DATA_W   = 88;
    localparam int OUT_USER_W   = 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Item kind, as carried on the input tuser and in a queued command
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_CHANGE = 1'b1
    } cmd_kind_t;

    // Classified command; for a change, slot0 is always a dirty piece
    typedef struct packed {
        cmd_kind_t               kind;
        logic                    persp;
        logic                    dual;
        logic [SLOT_W-1:0]       slot0;
        logic [CODE_FIELD_W-1:0] old0;
        logic [CODE_FIELD_W-1:0] new0;
        logic [SLOT_W-1:0]       slot1;
        logic [CODE_FIELD_W-1:0] old1;
        logic [CODE_FIELD_W-1:0] new1;
    } cmd_t;

    // Slot walker states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINAL
    } walk_state_t;

endpackage

/* hw/rtl/piece_pair_feature_delta_unit.sv */
// Piece-pair feature delta unit.
// Input channel s_axis: one transfer per item. tuser selects the item kind
// (write or change) and the perspective; a write stores one piece code, a
// change names up to two moved pieces with old and new codes.
// Output channel m_axis: removed/added pair feature indices, one transfer per
// clean piece slot walked and one for a pair of dirty pieces, tuser flags a
// meaningful second pair, tlast marks the final transfer of a change item.
// Writes and changes without a dirty piece give no output.
// With the walker idle, an accepted change passes the holding register and the
// queue into the walker's command register; its first result then moves through
// the table read and stage 1, stage 2 and the output register. A change holds
// the slot walker for a walk over every piece slot, plus the dirty-pair step
// with two pieces; it reads one piece-table entry per cycle unless stalled.
// A two-entry command queue lets the input keep taking items while a walk runs.
// Reset clears all control state; the piece table holds no value until written.
// When the receiver stalls, a running walk and its three-stage index pipeline hold
// in place, and input transfers stop once the queue and holding register are full.
module piece_pair_feature_delta_unit #(
    parameter int NUM_PIECES      = ppfd_pkg::NUM_PIECES_DEF,
    parameter int PIECE_CODE_BITS = ppfd_pkg::PIECE_CODE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // change_count, first_slot, first_old, first_new, second_slot, second_old, second_new
    input  logic [ppfd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation, perspective
    input  logic [ppfd_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // removed_first, added_first, removed_second, added_second, zero pad
    output logic [ppfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // second_valid
    output logic [ppfd_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);
    import ppfd_pkg::*;

    logic front_valid;
    cmd_t front_cmd;
    logic queue_ready;
    logic queue_valid;
    cmd_t queue_cmd;
    logic queue_pop;

    // Accept and classify
    ppfd_front #(
        .NUM_PIECES      (NUM_PIECES),
        .PIECE_CODE_BITS (PIECE_CODE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (front_valid),
        .cmd           (front_cmd),
        .cmd_ready     (queue_ready)
    );

    // Command queue
    ppfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_data  (front_cmd),
        .push_ready (queue_ready),
        .pop        (queue_pop),
        .pop_valid  (queue_valid),
        .pop_data   (queue_cmd)
    );

    // Piece table, slot walker and index pipeline
    ppfd_back #(
        .NUM_PIECES      (NUM_PIECES),
        .PIECE_CODE_BITS (PIECE_CODE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (queue_valid),
        .q_cmd         (queue_cmd),
        .q_pop         (queue_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* hw/rtl/ppfd_front.sv */
module ppfd_front #(
    parameter int NUM_PIECES      = ppfd_pkg::NUM_PIECES_DEF,
    parameter int PIECE_CODE_BITS = ppfd_pkg::PIECE_CODE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // change_count, first_slot, first_old, first_new, second_slot, second_old, second_new
    input  logic [ppfd_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // operation, perspective
    input  logic [ppfd_pkg::IN_USER_W-1:0] s_axis_tuser,
    output logic                           cmd_valid,
    output ppfd_pkg::cmd_t                 cmd,
    input  logic                           cmd_ready
);
    import ppfd_pkg::*;

    localparam int CW = (PIECE_CODE_BITS < CODE_FIELD_W) ? PIECE_CODE_BITS : CODE_FIELD_W;
    localparam logic [CODE_FIELD_W-1:0] CODE_MASK = {CODE_FIELD_W{1'b1}} >> (CODE_FIELD_W - CW);
    localparam logic [SLOT_W-1:0] NP_SLOT = SLOT_W'(NUM_PIECES);

    logic                    cmd_valid_reg;
    cmd_t                    cmd_reg;
    cmd_t                    cmd_next;
    logic                    keep_next;
    logic                    accept;
    cmd_kind_t               op;
    logic [COUNT_W-1:0]      count;
    logic [SLOT_W-1:0]       s0;
    logic [SLOT_W-1:0]       s1;
    logic [CODE_FIELD_W-1:0] o0;
    logic [CODE_FIELD_W-1:0] n0;
    logic [CODE_FIELD_W-1:0] o1;
    logic [CODE_FIELD_W-1:0] n1;
    logic                    d0;
    logic                    d1;

    // Unpack the transfer
    assign op    = cmd_kind_t'(s_axis_tuser[0]);
    assign count = s_axis_tdata[1:0];
    assign s0    = s_axis_tdata[7:2];
    assign o0    = s_axis_tdata[18:8] & CODE_MASK;
    assign n0    = s_axis_tdata[29:19] & CODE_MASK;
    assign s1    = s_axis_tdata[35:30];
    assign o1    = s_axis_tdata[46:36] & CODE_MASK;
    assign n1    = s_axis_tdata[57:47] & CODE_MASK;

    // Dirty pieces: king slots drop out, a repeated slot counts once
    assign d0 = (count != '0) && (s0 < NP_SLOT);
    assign d1 = count[1] && (s1 < NP_SLOT) && !(d0 && (s0 == s1));

    // Classify; a lone second dirty piece moves to the first place
    always_comb
    begin
        cmd_next.kind  = op;
        cmd_next.persp = s_axis_tuser[1];
        cmd_next.dual  = d0 && d1;
        cmd_next.slot0 = d0 ? s0 : s1;
        cmd_next.old0  = d0 ? o0 : o1;
        cmd_next.new0  = d0 ? n0 : n1;
        cmd_next.slot1 = s1;
        cmd_next.old1  = o1;
        cmd_next.new1  = n1;
        if (op == CMD_WRITE)
        begin
            // a write always targets the first slot field, whatever the count
            cmd_next.slot0 = s0;
            cmd_next.old0  = o0;
            cmd_next.new0  = n0;
            keep_next      = s0 < NP_SLOT;
        end
        else
        begin
            keep_next = d0 || d1;
        end
    end

    assign s_axis_tready = !cmd_valid_reg || cmd_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Holding register toward the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            cmd_valid_reg <= keep_next;
        end
        else if (cmd_ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

/* hw/rtl/ppfd_queue.sv */
module ppfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ppfd_pkg::cmd_t push_data,
    output logic           push_ready,
    input  logic           pop,
    output logic           pop_valid,
    output ppfd_pkg::cmd_t pop_data
);
    import ppfd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/ppfd_back.sv */
module ppfd_back #(
    parameter int NUM_PIECES      = ppfd_pkg::NUM_PIECES_DEF,
    parameter int PIECE_CODE_BITS = ppfd_pkg::PIECE_CODE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  ppfd_pkg::cmd_t                  q_cmd,
    output logic                            q_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // removed_first, added_first, removed_second, added_second, zero pad
    output logic [ppfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // second_valid
    output logic [ppfd_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);
    import ppfd_pkg::*;

    localparam int CW     = (PIECE_CODE_BITS < CODE_FIELD_W) ? PIECE_CODE_BITS : CODE_FIELD_W;
    localparam int DEPTH  = 2 * NUM_PIECES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(NUM_PIECES);
    localparam int PROD_W = 2 * CW;
    localparam int SUM_W  = (PROD_W > IDX_W + 1) ? PROD_W : IDX_W + 1;
    localparam int LANES  = 4;

    walk_state_t       state_reg;
    walk_state_t       state_next;
    cmd_t              cmd_reg;
    logic [CNT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0] slot_ext;
    logic              adv;
    logic              at_end;
    logic              dirty;
    logic              walk_last;
    logic              load;
    logic              mem_wr;
    logic              issue_valid;
    logic              issue_final;
    logic              issue_last;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    logic [CW-1:0]     mem [DEPTH];
    logic [CW-1:0]     rd_data_reg;

    logic              s1_valid_reg;
    logic              s1_final_reg;
    logic              s1_last_reg;
    logic              s1_sec_reg;
    logic [CW-1:0]     s1_old0_reg;
    logic [CW-1:0]     s1_new0_reg;
    logic [CW-1:0]     s1_old1_reg;
    logic [CW-1:0]     s1_new1_reg;

    logic [CW-1:0]     lane_x [LANES];
    logic [CW-1:0]     lane_y [LANES];
    logic [PROD_W-1:0] prod_reg [LANES];
    logic [CW-1:0]     lo_reg [LANES];
    logic [IDX_W-1:0]  idx [LANES];
    logic              s2_valid_reg;
    logic              s2_last_reg;
    logic              s2_sec_reg;

    logic              out_valid_reg;
    logic              out_last_reg;
    logic              out_sec_reg;
    logic [IDX_W-1:0]  out_idx_reg [LANES];

    // Whole pipeline moves when the output register can take a result
    assign adv = !out_valid_reg || m_axis_tready;

    assign slot_ext  = SLOT_W'(slot_reg);
    assign at_end    = slot_reg == CNT_W'(NUM_PIECES - 1);
    assign dirty     = (slot_ext == cmd_reg.slot0) || (cmd_reg.dual && (slot_ext == cmd_reg.slot1));
    // Single piece: last result is the top slot, or the one below when the piece sits on top
    assign walk_last = !cmd_reg.dual
                       && (at_end || ((slot_reg == CNT_W'(NUM_PIECES - 2))
                                      && (cmd_reg.slot0 == SLOT_W'(NUM_PIECES - 1))));

    assign rd_addr = cmd_reg.persp ? ADDR_W'(NUM_PIECES) + ADDR_W'(slot_reg) : ADDR_W'(slot_reg);
    assign wr_addr = q_cmd.persp ? ADDR_W'(NUM_PIECES) + ADDR_W'(q_cmd.slot0)
                                 : ADDR_W'(q_cmd.slot0);

    // Walker next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (q_cmd.kind == CMD_CHANGE))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (adv && at_end)
                begin
                    state_next = cmd_reg.dual ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Walker outputs
    always_comb
    begin
        q_pop       = 1'b0;
        mem_wr      = 1'b0;
        load        = 1'b0;
        issue_valid = 1'b0;
        issue_final = 1'b0;
        issue_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop  = q_valid;
                mem_wr = q_valid && (q_cmd.kind == CMD_WRITE);
                load   = q_valid && (q_cmd.kind == CMD_CHANGE);
            end
            ST_WALK:
            begin
                issue_valid = !dirty;
                issue_last  = walk_last;
            end
            ST_FINAL:
            begin
                issue_valid = 1'b1;
                issue_final = 1'b1;
                issue_last  = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Walker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                slot_reg <= '0;
            end
            else if ((state_reg == ST_WALK) && adv && !at_end)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= q_cmd;
        end
    end

    // Piece table, one port written from the queue, one read by the walker
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wr_addr] <= CW'(q_cmd.new0);
        end
        if (adv)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Stage 1: read data plus the codes it pairs with
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= issue_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_final_reg <= issue_final;
            s1_last_reg  <= issue_last;
            s1_sec_reg   <= cmd_reg.dual && !issue_final;
            s1_old0_reg  <= CW'(cmd_reg.old0);
            s1_new0_reg  <= CW'(cmd_reg.new0);
            s1_old1_reg  <= CW'(cmd_reg.old1);
            s1_new1_reg  <= CW'(cmd_reg.new1);
        end
    end

    // Lane operands; the final step pairs the two dirty pieces
    always_comb
    begin
        lane_x[0] = s1_final_reg ? s1_old1_reg : rd_data_reg;
        lane_y[0] = s1_old0_reg;
        lane_x[1] = s1_final_reg ? s1_new1_reg : rd_data_reg;
        lane_y[1] = s1_new0_reg;
        lane_x[2] = rd_data_reg;
        lane_y[2] = s1_old1_reg;
        lane_x[3] = rd_data_reg;
        lane_y[3] = s1_new1_reg;
    end

    // Stage 2: triangle product per lane, stage 3 adds the smaller code
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [CW-1:0] hi;
        logic [CW-1:0] lo;

        assign hi = (lane_x[i] > lane_y[i]) ? lane_x[i] : lane_y[i];
        assign lo = (lane_x[i] > lane_y[i]) ? lane_y[i] : lane_x[i];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                prod_reg[i] <= PROD_W'(hi) * PROD_W'(hi - CW'(1));
                lo_reg[i]   <= lo;
            end
        end

        assign idx[i] = IDX_W'((SUM_W'(prod_reg[i]) >> 1) + SUM_W'(lo_reg[i]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_last_reg    <= s1_last_reg;
            s2_sec_reg     <= s1_sec_reg;
            out_last_reg   <= s2_last_reg;
            out_sec_reg    <= s2_sec_reg;
            out_idx_reg[0] <= idx[0];
            out_idx_reg[1] <= idx[1];
            out_idx_reg[2] <= s2_sec_reg ? idx[2] : '0;
            out_idx_reg[3] <= s2_sec_reg ? idx[3] : '0;
        end
    end

    // Output transfer
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - 4 * IDX_W)'(0), out_idx_reg[3], out_idx_reg[2],
                            out_idx_reg[1], out_idx_reg[0]};
    assign m_axis_tuser  = OUT_USER_W'(out_sec_reg);
    assign m_axis_tlast  = out_last_reg;

    // The extra pair step only follows a two-piece walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) |-> cmd_reg.dual)
        else $error("final pair step without a second dirty piece");

    // A result with a second pair is never the closing one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sec_reg) |-> !out_last_reg)
        else $error("second pair result flagged last");

    // A stalled walk must not skip a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && !adv) |=> $stable(slot_reg))
        else $error("walk slot moved during output stall");

endmodule
